// ----- hdl/dks_pkg.sv -----
// Shared types and constants for the diagonal Kalman smoother.
// No dependencies.
package dks_pkg;
  localparam int unsigned Lanes = 4;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    ACT_PREDICT = 2'd0,
    ACT_UPDATE  = 2'd1,
    ACT_LOAD    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // divider request and reply
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage

// ----- hdl/dks_divider.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on dks_pkg.
module dks_divider (
  input  logic            clk,
  input  logic            rst,
  input  dks_pkg::div_req_t req,
  output dks_pkg::div_rsp_t rsp
);
  import dks_pkg::*;

  logic [63:0] quo;
  logic [33:0] rem;
  logic [32:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [33:0] trial;
  logic [33:0] shifted;

  // shift in next dividend bit and trial subtract
  assign shifted = {rem[32:0], quo[63]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // done pulses on the cycle the last quotient bit lands
      done <= !req.start && busy && (cnt == 7'd63);
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) busy <= 1'b0;
      end
    end
  end
  assign rsp = '{done: done, quotient: quo};
endmodule

// ----- hdl/diagonal_kalman_smoother_top.sv -----
// Top level: register file, per-lane state, sequencer over the shared divider.
// Depends on dks_pkg and dks_divider.
//
//  channel  | valid      | stall      | payload
//  in       | in_valid   | in_stall   | action, sample_0..3
//  out      | out_valid  | out_stall  | estimate_0..3
//  cfg      | cfg_we     | -          | cfg_index, cfg_data
//
// Predict, load and the unused code pass through ST_LANE and ST_OUT before
// out_valid rises. Update runs two divisions on each active lane (none when
// p + r is 0), all lanes sharing one divider.
// Reset (rst, synchronous) clears state to zero and r to 1.0.
// A result is held in the output register until taken; in_stall is high
// while an item is in work or its result waits.
module diagonal_kalman_smoother_top #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [dks_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             action,
  input  logic signed [31:0]     sample_0,
  input  logic signed [31:0]     sample_1,
  input  logic signed [31:0]     sample_2,
  input  logic signed [31:0]     sample_3,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     estimate_0,
  output logic signed [31:0]     estimate_1,
  output logic signed [31:0]     estimate_2,
  output logic signed [31:0]     estimate_3
);
  import dks_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LANE  = 6'b000010,
    ST_KWAIT = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_PWAIT = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic [31:0] qn [Lanes];
  logic [31:0] rn [Lanes];
  logic [31:0] var_r [Lanes];
  logic signed [31:0] est [Lanes];
  logic signed [31:0] smp [Lanes];
  action_t act;
  logic [1:0] lane;
  logic [16:0] gain;
  logic signed [33:0] diff;
  logic signed [51:0] prod;
  logic [63:0] pr;
  div_req_t dreq;
  div_rsp_t drsp;
  logic        div_start;
  logic [63:0] div_dividend;
  logic [32:0] div_divisor;
  logic [32:0] ssum;
  logic signed [35:0] newx;
  logic signed [31:0] res [Lanes];

  // configuration writes; indexes 0-3 set q, indexes 4-7 set r
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Lanes; i++) begin
        qn[i] <= '0;
        rn[i] <= 32'd65536;
      end
    end else if (cfg_we) begin
      if (cfg_index[2]) rn[cfg_index[1:0]] <= cfg_data;
      else              qn[cfg_index[1:0]] <= cfg_data;
    end
  end

  assign dreq = '{start: div_start, dividend: div_dividend, divisor: div_divisor};

  dks_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign ssum = {1'b0, var_r[lane]} + {1'b0, rn[lane]};
  assign newx = 36'(est[lane]) + 36'(prod >>> 16);
  assign in_stall = (state != ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      div_start    <= 1'b0;
      div_dividend <= '0;
      div_divisor  <= '0;
      lane         <= '0;
      for (int i = 0; i < Lanes; i++) begin
        var_r[i] <= '0;
        est[i]   <= '0;
      end
    end else begin
      // divider kicks off for the gain and again for the new variance
      div_start <= (state == ST_MUL) ||
                   (state == ST_LANE && act == ACT_UPDATE &&
                    32'(lane) < CHANNELS && ssum != '0);
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            act    <= action_t'(action);
            smp[0] <= sample_0;
            smp[1] <= sample_1;
            smp[2] <= sample_2;
            smp[3] <= sample_3;
            lane   <= '0;
            state  <= ST_LANE;
          end
        end
        ST_LANE: begin
          if (32'(lane) >= CHANNELS) begin
            state <= ST_OUT;
          end else begin
            case (act)
              ACT_PREDICT: begin
                for (int i = 0; i < Lanes; i++)
                  if (i < CHANNELS) begin
                    if ({1'b0, var_r[i]} + {1'b0, qn[i]} > 33'hFFFFFFFF)
                      var_r[i] <= '1;
                    else var_r[i] <= var_r[i] + qn[i];
                  end
                state <= ST_OUT;
              end
              ACT_LOAD: begin
                for (int i = 0; i < Lanes; i++)
                  if (i < CHANNELS) est[i] <= smp[i];
                state <= ST_OUT;
              end
              ACT_UPDATE: begin
                if (ssum == '0) begin
                  if (lane == 2'd3) state <= ST_OUT;
                  lane <= lane + 2'd1;
                end else begin
                  div_dividend <= {16'd0, var_r[lane], 16'd0};
                  div_divisor  <= ssum;
                  pr           <= var_r[lane] * rn[lane];
                  diff         <= 34'(smp[lane]) - 34'(est[lane]);
                  state        <= ST_KWAIT;
                end
              end
              default: state <= ST_OUT;
            endcase
          end
        end
        ST_KWAIT: begin
          if (drsp.done) begin
            gain  <= drsp.quotient[16:0];
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod         <= $signed({1'b0, gain}) * diff;
          div_dividend <= pr;
          div_divisor  <= ssum;
          state        <= ST_PWAIT;
        end
        ST_PWAIT: begin
          if (drsp.done) begin
            var_r[lane] <= drsp.quotient[31:0];
            if (newx > 36'sh07FFFFFFF)       est[lane] <= 32'h7FFFFFFF;
            else if (newx < -36'sh080000000) est[lane] <= 32'h80000000;
            else                             est[lane] <= newx[31:0];
            if (lane == 2'd3) state <= ST_OUT;
            else state <= ST_LANE;
            lane <= lane + 2'd1;
          end
        end
        ST_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // unused lanes read as zero
  always_comb begin
    for (int i = 0; i < Lanes; i++) res[i] = (i < CHANNELS) ? est[i] : '0;
  end
  assign estimate_0 = res[0];
  assign estimate_1 = res[1];
  assign estimate_2 = res[2];
  assign estimate_3 = res[3];
endmodule

// ----- tb/dks_checker.sv -----
// Checker for the diagonal Kalman smoother: watches the config port and both
// item channels, predicts the estimates and compares. Depends on dks_pkg.
module dks_checker #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [dks_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic signed [31:0]          sample_0,
  input  logic signed [31:0]          sample_1,
  input  logic signed [31:0]          sample_2,
  input  logic signed [31:0]          sample_3,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [31:0]          estimate_0,
  input  logic signed [31:0]          estimate_1,
  input  logic signed [31:0]          estimate_2,
  input  logic signed [31:0]          estimate_3,
  output int                          errors,
  output int                          pending
);
  import dks_pkg::*;

  typedef logic signed [31:0] est_vec_t [4];

  logic [31:0]        q_noise [4];
  logic [31:0]        r_noise [4];
  logic [31:0]        var_st  [4];
  logic signed [31:0] est_st  [4];
  logic [127:0]       est_fifo [$];

  // one lane of the measurement update
  task automatic blend_lane(input int i, input logic signed [31:0] z);
    logic [63:0]        p, r, s, k;
    logic signed [65:0] d, prod, delta, nx;
    p = var_st[i];
    r = r_noise[i];
    s = p + r;
    if (s == 0) begin
      var_st[i] = 0;
      return;
    end
    k = (p << 16) / s;
    d = 66'(z) - 66'(est_st[i]);
    prod = $signed({2'b0, k}) * d;
    delta = prod >>> 16;
    nx = 66'(est_st[i]) + delta;
    if (nx > 66'sd2147483647) est_st[i] = 32'h7fffffff;
    else if (nx < -66'sd2147483648) est_st[i] = 32'h80000000;
    else est_st[i] = nx[31:0];
    var_st[i] = 32'((p * r) / s);
  endtask

  task automatic apply_item(input action_t act, input est_vec_t z);
    logic [32:0]  sum;
    logic [127:0] res;
    for (int i = 0; i < CHANNELS; i++) begin
      case (act)
        ACT_PREDICT: begin
          sum = {1'b0, var_st[i]} + {1'b0, q_noise[i]};
          var_st[i] = sum[32] ? 32'hffffffff : sum[31:0];
        end
        ACT_UPDATE: blend_lane(i, z[i]);
        ACT_LOAD: est_st[i] = z[i];
        default: ;
      endcase
    end
    res = '0;
    for (int i = 0; i < CHANNELS; i++) res[32*i +: 32] = est_st[i];
    est_fifo.push_back(res);
  endtask

  assign pending = est_fifo.size();

  // watch and compare on each rising edge
  always @(posedge clk) begin
    logic [127:0] exp_v, got;
    est_vec_t     z;
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        q_noise[i] = 0; r_noise[i] = 32'd65536; var_st[i] = 0; est_st[i] = 0;
      end
      est_fifo.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index < 4) q_noise[cfg_index] = cfg_data;
        else r_noise[cfg_index - 4] = cfg_data;
      end
      if (out_valid && !out_stall) begin
        got = {estimate_3, estimate_2, estimate_1, estimate_0};
        if (est_fifo.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected item: %h", got);
        end else begin
          exp_v = est_fifo.pop_front();
          for (int i = 0; i < 4; i++)
            if (got[32*i +: 32] !== exp_v[32*i +: 32]) begin
              errors++;
              if (errors <= 10)
                $display("estimate_%0d mismatch: expected %h got %h", i,
                         exp_v[32*i +: 32], got[32*i +: 32]);
            end
        end
      end
      if (in_valid && !in_stall) begin
        z[0] = sample_0; z[1] = sample_1; z[2] = sample_2; z[3] = sample_3;
        apply_item(action_t'(action), z);
      end
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top for diagonal_kalman_smoother_top: clock, reset, stimulus
// and verdict. Depends on dks_pkg, the block and dks_checker.
module tb_top;
  import dks_pkg::*;

  logic               clk, rst, cfg_we, in_valid, in_stall, out_valid, out_stall;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]        cfg_data;
  logic [1:0]         action;
  logic signed [31:0] sample_0, sample_1, sample_2, sample_3;
  logic signed [31:0] estimate_0, estimate_1, estimate_2, estimate_3;
  int                 errors, pending, send_idle, recv_idle;
  longint             cycles;

  diagonal_kalman_smoother_top i_dut (.*);
  dks_checker i_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // timeout; about 700 items plus stalls fit well below this
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("diagonal_kalman_smoother_top test failed");
        $finish;
      end
    end
  end

  // receiver stall, redrawn each falling edge
  always @(negedge clk)
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < recv_idle);

  // valid stays up between back-to-back items; it drops while idling
  task automatic send(input action_t act, input logic [31:0] a, b, c, d);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    action <= act; sample_0 <= a; sample_1 <= b; sample_2 <= c; sample_3 <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx[CfgIdxW-1:0]; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_sample();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rnd_noise();
    case ($urandom_range(4))
      0: return 0;
      1: return 32'hffffffff;
      2: return $urandom_range(0, 32'h00040000);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int n);
    action_t act;
    int      pick;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(19);
      act = pick < 7 ? ACT_PREDICT : pick < 16 ? ACT_UPDATE :
            pick < 19 ? ACT_LOAD : ACT_NONE;
      send(act, rnd_sample(), rnd_sample(), rnd_sample(), rnd_sample());
    end
  endtask

  initial begin
    rst = 1; cfg_we = 0; cfg_index = '0; cfg_data = '0; in_valid = 0;
    action = '0; sample_0 = 0; sample_1 = 0; sample_2 = 0;
    sample_3 = 0; send_idle = 0; recv_idle = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: reset noise, zero denominator, extremes, unused action
    send(ACT_UPDATE, 32'h7fffffff, 32'h80000000, 32'h00010000, 32'hffff0000);
    send(ACT_NONE, 32'h12345678, 0, 0, 0);
    send(ACT_LOAD, 32'h80000000, 32'h7fffffff, 0, 32'hffffffff);
    drain();
    for (int i = 0; i < 4; i++) write_reg(i, 32'hffffffff);
    for (int i = 4; i < 8; i++) write_reg(i, 0);
    send(ACT_UPDATE, 32'h7fffffff, 0, 0, 0);  // zero denominator
    send(ACT_PREDICT, 0, 0, 0, 0);
    send(ACT_PREDICT, 0, 0, 0, 0);            // variance saturates
    send(ACT_UPDATE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send(ACT_LOAD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    drain();
    for (int i = 4; i < 8; i++) write_reg(i, 32'hffffffff);
    send(ACT_PREDICT, 0, 0, 0, 0);
    send(ACT_UPDATE, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send(ACT_UPDATE, 32'h00010000, 32'hfffe0000, 0, 32'h00008000);
    send(ACT_NONE, 0, 0, 0, 0);
    drain();

    // random phases over several register settings and idle mixes
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 8; i++) write_reg(i, rnd_noise());
      send_idle = ph < 2 ? 35 : ph < 4 ? 77 : 0;
      recv_idle = ph < 2 ? 77 : ph < 4 ? 35 : 0;
      random_phase(115);
      drain();
    end

    if (errors == 0 && pending == 0)
      $display("diagonal_kalman_smoother_top test passed");
    else
      $display("diagonal_kalman_smoother_top test failed");
    $finish;
  end
endmodule

// ----- files.f -----
hdl/dks_pkg.sv
hdl/dks_divider.sv
hdl/diagonal_kalman_smoother_top.sv
tb/dks_checker.sv
tb/tb_top.sv
